@@ rtl/sfr_pkg.sv @@
package sfr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HDR_A  = 3'd1,
    PH_CMD    = 3'd2,
    PH_LEN    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHK_HI = 3'd5,
    PH_CHK_LO = 3'd6
  } phase_t;

  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_ACCEPT  = 2'd1;
  localparam logic [1:0] EV_ABORT   = 2'd2;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [7:0]  HDR_FIRST   = 8'h41;
  localparam logic [7:0]  HDR_SECOND  = 8'h54;
  localparam logic [15:0] SUM_SEED    = 16'hAB34;
  localparam logic [15:0] TICK_MAX    = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd10;

  localparam int          PADDR_W      = 2;
  localparam logic [1:0]  ADDR_TIMEOUT = 2'd0;

endpackage

@@ rtl/serial_frame_receiver.sv @@
// serial_frame_receiver: header/command/length/payload/check-word deframer
// a result is registered and shown in the cycle after its word is accepted
// throughput: one word per cycle; input stalls only while a result waits
// on a low out_ready (the result register decouples the two sides)
// reset (rst, synchronous): parser idle, sum seeded, timeout back to 10 ticks
module serial_frame_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    event_res,
  output logic [7:0]                    data_byte,
  output logic [7:0]                    data_index,
  output logic [7:0]                    frame_cmd,
  output logic [7:0]                    frame_length,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfr_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  sfr_pkg::phase_t phase, phase_next;
  logic [7:0]  command_reg, command_reg_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [7:0]  payload_pos, payload_pos_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  check_high, check_high_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic [15:0] idle_timeout_ticks;

  logic        accept;
  logic        is_byte;
  logic [15:0] ticks_inc;
  logic        timed_out;
  logic [7:0]  pos_inc;
  logic        check_ok;

  logic        res_emit;
  logic [1:0]  res_event;
  logic [7:0]  res_byte;
  logic [7:0]  res_index;

  assign pready   = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_byte  = (func == sfr_pkg::FUNC_BYTE);

  assign ticks_inc = (idle_ticks == sfr_pkg::TICK_MAX) ? idle_ticks : idle_ticks + 16'd1;
  assign timed_out = (phase != sfr_pkg::PH_IDLE) && (ticks_inc >= idle_timeout_ticks);
  assign pos_inc   = payload_pos + 8'd1;
  assign check_ok  = (running_sum == {check_high, rx_byte});

  always_comb begin
    prdata = 32'd0;
    if (paddr == sfr_pkg::ADDR_TIMEOUT) begin
      prdata = {16'd0, idle_timeout_ticks};
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (!is_byte) begin
        if (timed_out) begin
          phase_next = sfr_pkg::PH_IDLE;
        end
      end else begin
        case (phase)
          sfr_pkg::PH_IDLE: begin
            if (rx_byte == sfr_pkg::HDR_FIRST) phase_next = sfr_pkg::PH_HDR_A;
          end
          sfr_pkg::PH_HDR_A: begin
            // a broken header drops back to idle, the byte is not a new 'A'
            phase_next = (rx_byte == sfr_pkg::HDR_SECOND) ? sfr_pkg::PH_CMD
                                                          : sfr_pkg::PH_IDLE;
          end
          sfr_pkg::PH_CMD: phase_next = sfr_pkg::PH_LEN;
          sfr_pkg::PH_LEN: begin
            phase_next = (rx_byte == 8'd0) ? sfr_pkg::PH_CHK_HI : sfr_pkg::PH_DATA;
          end
          sfr_pkg::PH_DATA: begin
            if (pos_inc == length_reg) phase_next = sfr_pkg::PH_CHK_HI;
          end
          sfr_pkg::PH_CHK_HI: phase_next = sfr_pkg::PH_CHK_LO;
          sfr_pkg::PH_CHK_LO: begin
            // on a mismatch keep waiting on the low check byte
            if (check_ok) phase_next = sfr_pkg::PH_IDLE;
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    command_reg_next = command_reg;
    length_reg_next  = length_reg;
    payload_pos_next = payload_pos;
    running_sum_next = running_sum;
    check_high_next  = check_high;
    idle_ticks_next  = idle_ticks;
    res_emit         = 1'b0;
    res_event        = sfr_pkg::EV_PAYLOAD;
    res_byte         = 8'd0;
    res_index        = 8'd0;
    if (accept) begin
      if (!is_byte) begin
        idle_ticks_next = ticks_inc;
        if (timed_out) begin
          res_emit  = 1'b1;
          res_event = sfr_pkg::EV_ABORT;
        end
      end else begin
        idle_ticks_next = 16'd0;
        case (phase)
          sfr_pkg::PH_CMD: begin
            command_reg_next = rx_byte;
            running_sum_next = sfr_pkg::SUM_SEED + {8'd0, rx_byte};
          end
          sfr_pkg::PH_LEN: begin
            length_reg_next  = rx_byte;
            running_sum_next = running_sum + {8'd0, rx_byte};
            payload_pos_next = 8'd0;
          end
          sfr_pkg::PH_DATA: begin
            running_sum_next = running_sum + {8'd0, rx_byte};
            payload_pos_next = pos_inc;
            res_emit         = 1'b1;
            res_event        = sfr_pkg::EV_PAYLOAD;
            res_byte         = rx_byte;
            res_index        = payload_pos;
          end
          sfr_pkg::PH_CHK_HI: check_high_next = rx_byte;
          sfr_pkg::PH_CHK_LO: begin
            if (check_ok) begin
              res_emit  = 1'b1;
              res_event = sfr_pkg::EV_ACCEPT;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= sfr_pkg::PH_IDLE;
      command_reg        <= 8'd0;
      length_reg         <= 8'd0;
      payload_pos        <= 8'd0;
      running_sum        <= sfr_pkg::SUM_SEED;
      check_high         <= 8'd0;
      idle_ticks         <= 16'd0;
      idle_timeout_ticks <= sfr_pkg::TIMEOUT_RST;
      out_valid          <= 1'b0;
    end else begin
      phase       <= phase_next;
      command_reg <= command_reg_next;
      length_reg  <= length_reg_next;
      payload_pos <= payload_pos_next;
      running_sum <= running_sum_next;
      check_high  <= check_high_next;
      idle_ticks  <= idle_ticks_next;
      if (psel && penable && pwrite && pready && (paddr == sfr_pkg::ADDR_TIMEOUT)) begin
        idle_timeout_ticks <= pwdata[15:0];
      end
      if (in_ready) begin
        out_valid <= res_emit;
      end
    end
  end

  // result register, loaded with each new result whenever the previous one has gone
  always_ff @(posedge clk) begin
    if (in_ready && res_emit) begin
      event_res    <= res_event;
      data_byte    <= res_byte;
      data_index   <= res_index;
      frame_cmd    <= command_reg;
      frame_length <= length_reg;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

  a_payload_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == sfr_pkg::EV_PAYLOAD) |-> (data_index < frame_length))
    else $error("payload index beyond declared length");

  a_byte_clears_ticks: assert property (@(posedge clk) disable iff (rst)
    (accept && is_byte) |=> (idle_ticks == 16'd0))
    else $error("idle tick count not cleared by a byte");

  a_cmd_to_len: assert property (@(posedge clk) disable iff (rst)
    (accept && is_byte && phase == sfr_pkg::PH_CMD) |=> (phase == sfr_pkg::PH_LEN))
    else $error("command byte did not advance to length");

endmodule
